@@ rtl/ssns_pkg.sv @@
// Shared types, constants and segment decode for the seven-segment number scanner.
package ssns_pkg;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_RUN
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic zero_count;
    logic last;
    logic slot_free;
  } status_t;

  localparam logic [7:0] SEG_FALLBACK = 8'h5C;

  localparam logic [7:0] SEG_TABLE [10] = '{
    8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66, 8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F
  };

  localparam logic [15:0] RECIP_TEN = 16'd52429;
  localparam int RECIP_SHIFT = 19;

  function automatic logic [7:0] seg_for(input logic [3:0] digit);
    logic [7:0] pattern;
    if (digit > 4'd9) begin
      pattern = SEG_FALLBACK;
    end else begin
      pattern = SEG_TABLE[digit];
    end
    return pattern;
  endfunction

endpackage

@@ rtl/ssns_if.sv @@
// Valid/ready channel interfaces for numbers in and digit results out.
interface ssns_num_if;
  logic        valid;
  logic        ready;
  logic [15:0] value;
  logic [2:0]  start_position;
  logic [3:0]  digit_count;

  modport source (output valid, output value, output start_position, output digit_count,
                  input ready);
  modport sink (input valid, input value, input start_position, input digit_count,
                output ready);
endinterface

interface ssns_dig_if;
  logic       valid;
  logic       ready;
  logic [2:0] select_code;
  logic [7:0] segments;
  logic       last_digit;

  modport source (output valid, output select_code, output segments, output last_digit,
                  input ready);
  modport sink (input valid, input select_code, input segments, input last_digit,
                output ready);
endinterface

@@ rtl/ssns_ctrl.sv @@
// Controller state machine: accepts a number, then steps the datapath once per digit.
module ssns_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  ssns_pkg::status_t status,
  output ssns_pkg::cmd_t    cmd
);

  ssns_pkg::state_t state;
  ssns_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssns_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      ssns_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && !status.zero_count) begin
          cmd.load   = 1'b1;
          state_next = ssns_pkg::ST_RUN;
        end
      end
      ssns_pkg::ST_RUN: begin
        if (status.slot_free) begin
          cmd.step = 1'b1;
          if (status.last) begin
            state_next = ssns_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ssns_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/ssns_dp.sv @@
// Datapath: divide-by-ten step, position and select tracking, output register.
module ssns_dp #(
  parameter int DISPLAY_DIGITS = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [15:0]       in_value,
  input  logic [2:0]        in_start,
  input  logic [3:0]        in_count,
  input  ssns_pkg::cmd_t    cmd,
  output ssns_pkg::status_t status,
  ssns_dig_if.source        digit
);

  localparam logic [3:0] MaxCount = 4'(DISPLAY_DIGITS);

  logic [15:0] num;
  logic [3:0]  count;
  logic [3:0]  index;
  logic [2:0]  start;
  logic [2:0]  held_select;
  logic        out_valid;
  logic [2:0]  out_select;
  logic [7:0]  out_seg;
  logic        out_last;

  logic [31:0] prod;
  logic [15:0] quot;
  logic [15:0] quot_x10;
  logic [3:0]  rem;
  logic [3:0]  pos;
  logic [3:0]  count_sat;
  logic        on_display;

  assign prod       = 32'(num) * 32'(ssns_pkg::RECIP_TEN);
  assign quot       = 16'(prod >> ssns_pkg::RECIP_SHIFT);
  assign quot_x10   = 16'({quot, 3'b000}) + 16'({quot, 1'b0});
  assign rem        = 4'(num - quot_x10);
  assign pos        = 4'({1'b0, start}) + count - 4'd1 - index;
  assign on_display = pos < MaxCount;
  assign count_sat  = (in_count > MaxCount) ? MaxCount : in_count;

  assign status.zero_count = in_count == 4'd0;
  assign status.last       = (index + 4'd1) == count;
  assign status.slot_free  = !out_valid || digit.ready;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      num   <= in_value;
      start <= in_start;
      count <= count_sat;
      index <= 4'd0;
    end else if (cmd.step) begin
      num   <= quot;
      index <= index + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_select <= 3'd7;
      out_valid   <= 1'b0;
    end else if (cmd.step) begin
      out_valid <= 1'b1;
      if (on_display) begin
        held_select <= ~pos[2:0];
      end
    end else if (digit.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step) begin
      out_select <= on_display ? ~pos[2:0] : held_select;
      out_seg    <= ssns_pkg::seg_for(rem);
      out_last   <= status.last;
    end
  end

  assign digit.valid       = out_valid;
  assign digit.select_code = out_select;
  assign digit.segments    = out_seg;
  assign digit.last_digit  = out_last;

  a_rem_decimal: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> rem < 4'd10)
    else $error("remainder of divide-by-ten out of range");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    cmd.step |-> index < count)
    else $error("digit step past saturated count");

  a_step_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.step |=> out_valid)
    else $error("digit step did not fill output register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !digit.ready) |-> !cmd.step)
    else $error("stalled digit overwritten");

endmodule

@@ rtl/seven_segment_number_scanner.sv @@
// Top level of the multiplexed seven-segment decimal number scanner.
//
//   channel  role  payload
//   number   sink  value[15:0], start_position[2:0], digit_count[3:0]
//   digit    src   select_code[2:0], segments[7:0], last_digit
//
// An item is accepted, then its digits come one at a time from the single divide-by-ten unit,
// with digit_count capped at DISPLAY_DIGITS.
// A zero digit_count is accepted and produces no digits.
// The next number is accepted while the last digit still waits in the output register.
// A stalled digit output holds the digit and pauses the divide steps.
// Reset (synchronous, rst high) idles the controller and sets the held select to 7.
module seven_segment_number_scanner #(
  parameter int DISPLAY_DIGITS = 8
) (
  input logic         clk,
  input logic         rst,
  ssns_num_if.sink    number,
  ssns_dig_if.source  digit
);

  ssns_pkg::cmd_t    cmd;
  ssns_pkg::status_t status;

  ssns_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (number.valid),
    .in_ready (number.ready),
    .status   (status),
    .cmd      (cmd)
  );

  ssns_dp #(
    .DISPLAY_DIGITS (DISPLAY_DIGITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_value (number.value),
    .in_start (number.start_position),
    .in_count (number.digit_count),
    .cmd      (cmd),
    .status   (status),
    .digit    (digit)
  );

endmodule
